### design/chic_pkg.sv
// shared types, constants and helper functions of the compass heading block
`default_nettype none

package chic_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_BITS  = 6;
    localparam int ACC_FRAC         = 16;
    localparam int PRESCALE         = 24;
    localparam int DIFF_W           = SAMPLE_WIDTH + 1;
    localparam int CORDIC_W         = DIFF_W + PRESCALE + 3;
    localparam int Z_W              = 26;
    localparam int HEADING_W        = 15;
    localparam int OCT_W            = 3;
    localparam int REQ_W            = 2;
    localparam int ATAN_W           = 22;
    localparam int TAB_IDX_W        = 5;
    localparam int TAB_LEN          = 24;
    localparam int ROUND_SH         = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [Z_W-1:0] DEG90_Q  = Z_W'(90 <<< ACC_FRAC);
    localparam logic signed [Z_W-1:0] DEG360_Q = Z_W'(360 <<< ACC_FRAC);
    localparam logic signed [Z_W-1:0] RND_HALF = Z_W'(1 <<< (ROUND_SH - 1));
    localparam logic [HEADING_W:0]    HEADING_FULL = (HEADING_W+1)'(360 <<< ANGLE_FRAC_BITS);
    localparam int OCT_SPAN = 45 <<< ANGLE_FRAC_BITS;
    localparam int OCT_HALF = OCT_SPAN / 2;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CAL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HEAD  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OFFS,
        ST_CORD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]               req_type;
        logic signed [SAMPLE_WIDTH-1:0] sample_x;
        logic signed [SAMPLE_WIDTH-1:0] sample_y;
        logic signed [SAMPLE_WIDTH-1:0] sample_z;
    } t_in;

    typedef struct packed {
        logic [HEADING_W-1:0]           heading;
        logic [OCT_W-1:0]               octant;
        logic                           heading_valid;
        logic signed [SAMPLE_WIDTH-1:0] offset_x;
        logic signed [SAMPLE_WIDTH-1:0] offset_y;
        logic signed [SAMPLE_WIDTH-1:0] offset_z;
    } t_out;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic signed [SAMPLE_WIDTH-1:0] z;
    } t_offsets;

    typedef struct packed {
        logic [HEADING_W-1:0] heading;
        logic [OCT_W-1:0]     octant;
    } t_angle;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // midpoint truncated toward zero
    function automatic logic signed [SAMPLE_WIDTH-1:0] midpoint(
        input logic signed [SAMPLE_WIDTH-1:0] hi,
        input logic signed [SAMPLE_WIDTH-1:0] lo
    );
        logic signed [SAMPLE_WIDTH:0] s;
        s = (SAMPLE_WIDTH+1)'(hi) + (SAMPLE_WIDTH+1)'(lo);
        s = s + (SAMPLE_WIDTH+1)'(s[SAMPLE_WIDTH]);
        return SAMPLE_WIDTH'(s >>> 1);
    endfunction

    // sector count of the rounded heading, north wraps to zero
    function automatic logic [OCT_W-1:0] octant_of(input logic [HEADING_W-1:0] h);
        logic [OCT_W:0] cnt;
        cnt = '0;
        for (int k = 1; k <= 8; k++) begin
            if (h >= HEADING_W'(OCT_SPAN * k - OCT_HALF)) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt[OCT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/chic_cal.sv
// per-axis min/max tracking and hard-iron offsets
`default_nettype none

module chic_cal
    import chic_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic [REQ_W-1:0]               i_req,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_z,
    output t_offsets                            o_off
);

    logic signed [SAMPLE_WIDTH-1:0] r_max [3];
    logic signed [SAMPLE_WIDTH-1:0] r_min [3];
    logic signed [SAMPLE_WIDTH-1:0] n_max [3];
    logic signed [SAMPLE_WIDTH-1:0] n_min [3];
    logic signed [SAMPLE_WIDTH-1:0] w_s   [3];

    assign w_s[0] = i_x;
    assign w_s[1] = i_y;
    assign w_s[2] = i_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_max[a] = r_max[a];
            n_min[a] = r_min[a];
            if (i_load) begin
                if (i_req == REQ_START) begin
                    n_max[a] = w_s[a];
                    n_min[a] = w_s[a];
                end else if (i_req == REQ_CAL) begin
                    if (w_s[a] > r_max[a]) begin
                        n_max[a] = w_s[a];
                    end
                    if (w_s[a] < r_min[a]) begin
                        n_min[a] = w_s[a];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (!i_rst_n) begin
                r_max[a] <= '0;
                r_min[a] <= '0;
            end else begin
                r_max[a] <= n_max[a];
                r_min[a] <= n_min[a];
            end
        end
    end

    assign o_off.x = midpoint(r_max[0], r_min[0]);
    assign o_off.y = midpoint(r_max[1], r_min[1]);
    assign o_off.z = midpoint(r_max[2], r_min[2]);

endmodule

`default_nettype wire

### design/chic_cordic.sv
// iterative cordic vectoring unit giving heading and octant
`default_nettype none

module chic_cordic
    import chic_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DIFF_W-1:0] i_dx,
    input  wire logic signed [DIFF_W-1:0] i_dy,
    output logic                          o_done,
    output t_angle                        o_res
);

    localparam int STEP_W = $clog2(CORDIC_STEPS + 2);
    localparam logic [STEP_W-1:0] STEP_ROUND = STEP_W'(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] STEP_FIN   = STEP_W'(CORDIC_STEPS + 1);

    logic                       r_busy;
    logic [STEP_W-1:0]          r_step;
    logic                       r_zero;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [Z_W-1:0]      r_z;
    logic [HEADING_W-1:0]       r_head;
    logic                       r_done;
    t_angle                     r_res;

    logic signed [DIFF_W:0]     w_px;
    logic signed [DIFF_W:0]     w_py;
    logic signed [Z_W-1:0]      w_pz;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [Z_W-1:0]      w_atan;
    logic signed [Z_W-1:0]      w_zf;
    logic signed [Z_W-1:0]      w_zr;
    logic [HEADING_W:0]         w_hr;
    logic [HEADING_W-1:0]       w_head;

    // quadrant pre-rotation on the raw differences
    always_comb begin
        w_px = (DIFF_W+1)'(i_dy);
        w_py = (DIFF_W+1)'(i_dx);
        w_pz = '0;
        if (i_dy[DIFF_W-1]) begin
            if (!i_dx[DIFF_W-1]) begin
                w_px = (DIFF_W+1)'(i_dx);
                w_py = -(DIFF_W+1)'(i_dy);
                w_pz = DEG90_Q;
            end else begin
                w_px = -(DIFF_W+1)'(i_dx);
                w_py = (DIFF_W+1)'(i_dy);
                w_pz = -DEG90_Q;
            end
        end
    end

    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = Z_W'(atan_q16(TAB_IDX_W'(r_step)));

    // wrap, round half up, fold 360 to 0
    always_comb begin
        w_zf = r_z[Z_W-1] ? r_z + DEG360_Q : r_z;
        w_zr = (w_zf + RND_HALF) >>> ROUND_SH;
        w_hr = w_zr[HEADING_W:0];
        if (w_hr >= HEADING_FULL) begin
            w_hr = w_hr - HEADING_FULL;
        end
        w_head = w_hr[HEADING_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_FIN) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed(CORDIC_W'(w_px)) <<< PRESCALE;
            r_y    <= $signed(CORDIC_W'(w_py)) <<< PRESCALE;
            r_z    <= w_pz;
            r_zero <= (i_dx == '0) && (i_dy == '0);
        end else if (r_busy) begin
            if (r_step == STEP_FIN) begin
                r_res.heading <= r_zero ? '0 : r_head;
                r_res.octant  <= r_zero ? '0 : octant_of(r_head);
            end else if (r_step == STEP_ROUND) begin
                r_head <= w_head;
            end else if (!r_y[CORDIC_W-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

### design/compass_heading_with_hard_iron_cal.sv
// top level: compass heading with hard-iron calibration
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out)
//
// heading item: runs from transfer through the offset and cordic states to the
//   output register, with the single cordic shift/add unit doing one step a cycle
// calibration items: one min/max update and the offset adders
// o_in_ready is high only while idle; one item in flight at a time
// a stalled result holds in the output register, the next item may still transfer
// synchronous active-low reset clears the min/max values and all control
`default_nettype none

module compass_heading_with_hard_iron_cal
    import chic_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_state                         r_state;
    t_state                         n_state;
    logic [REQ_W-1:0]               r_req;
    logic signed [SAMPLE_WIDTH-1:0] r_sx;
    logic signed [SAMPLE_WIDTH-1:0] r_sy;
    logic                           r_out_valid;
    t_out                           r_out;

    logic                           w_in_xfer;
    logic                           w_start;
    logic                           w_load;
    logic                           w_head;
    logic                           w_done;
    t_offsets                       w_off;
    t_angle                         w_ang;
    logic signed [DIFF_W-1:0]       w_dx;
    logic signed [DIFF_W-1:0]       w_dy;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_head    = (r_req == REQ_HEAD);
    assign w_dx      = DIFF_W'(r_sx) - DIFF_W'(w_off.x);
    assign w_dy      = DIFF_W'(r_sy) - DIFF_W'(w_off.y);

    chic_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_xfer),
        .i_req   (i_in_data.req_type),
        .i_x     (i_in_data.sample_x),
        .i_y     (i_in_data.sample_y),
        .i_z     (i_in_data.sample_z),
        .o_off   (w_off)
    );

    chic_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_done),
        .o_res   (w_ang)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_OFFS;
                end
            end
            ST_OFFS: begin
                n_state = w_head ? ST_CORD : ST_DONE;
            end
            ST_CORD: begin
                if (w_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_start    = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_OFFS: w_start    = w_head;
            ST_CORD: ;
            ST_DONE: w_load     = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req <= i_in_data.req_type;
            r_sx  <= i_in_data.sample_x;
            r_sy  <= i_in_data.sample_y;
        end
        if (w_load) begin
            r_out.heading       <= w_head ? w_ang.heading : '0;
            r_out.octant        <= w_head ? w_ang.octant : '0;
            r_out.heading_valid <= w_head;
            r_out.offset_x      <= w_off.x;
            r_out.offset_y      <= w_off.y;
            r_out.offset_z      <= w_off.z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_in_cord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == ST_CORD)
        else $error("cordic finished outside of the cordic state");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {1'b0, o_out_data.heading} < HEADING_FULL)
        else $error("heading out of range");

    a_cal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.heading_valid |->
            o_out_data.heading == '0 && o_out_data.octant == '0)
        else $error("calibration result carries a heading");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !w_load)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the compass heading block with hard-iron calibration
`timescale 1ns / 100ps

module tb;
    import chic_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 640;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    class heading_book;
        logic signed [SAMPLE_WIDTH-1:0] peak [3];
        logic signed [SAMPLE_WIDTH-1:0] trough [3];
        t_out owed_fixes [$];
        int mismatches;

        function new();
            for (int a = 0; a < 3; a++) begin
                peak[a] = '0;
                trough[a] = '0;
            end
            mismatches = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        function longint cordic_heading(longint dx, longint dy);
            longint x, y, z, t, xs, ys;
            if (dx == 0 && dy == 0) begin
                return 0;
            end
            x = dy <<< PRESCALE;
            y = dx <<< PRESCALE;
            z = 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = longint'(90) <<< ACC_FRAC;
                end else begin
                    t = x; x = -y; y = t; z = -(longint'(90) <<< ACC_FRAC);
                end
            end
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z = z + ATAN_DEG[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - ATAN_DEG[i];
                end
            end
            if (z < 0) begin
                z = z + (longint'(360) <<< ACC_FRAC);
            end
            z = (z + (longint'(1) <<< (ACC_FRAC - ANGLE_FRAC_BITS - 1)))
                >>> (ACC_FRAC - ANGLE_FRAC_BITS);
            if (z >= (longint'(360) <<< ANGLE_FRAC_BITS)) begin
                z = z - (longint'(360) <<< ANGLE_FRAC_BITS);
            end
            return z;
        endfunction

        function logic [OCT_W-1:0] sector_of(longint h);
            longint q;
            q = (2 * h + (longint'(45) <<< ANGLE_FRAC_BITS)) / (longint'(90) <<< ANGLE_FRAC_BITS);
            return OCT_W'(q);
        endfunction

        function void note_sample(t_in item);
            logic signed [SAMPLE_WIDTH-1:0] s [3];
            int mid [3];
            t_out fix;
            longint h;
            s[0] = item.sample_x;
            s[1] = item.sample_y;
            s[2] = item.sample_z;
            case (item.req_type)
                REQ_START: begin
                    for (int a = 0; a < 3; a++) begin
                        peak[a] = s[a];
                        trough[a] = s[a];
                    end
                end
                REQ_CAL: begin
                    for (int a = 0; a < 3; a++) begin
                        if (s[a] > peak[a]) peak[a] = s[a];
                        if (s[a] < trough[a]) trough[a] = s[a];
                    end
                end
                default: ;
            endcase
            for (int a = 0; a < 3; a++) begin
                mid[a] = (int'(peak[a]) + int'(trough[a])) / 2;
            end
            fix = '0;
            fix.offset_x = SAMPLE_WIDTH'(mid[0]);
            fix.offset_y = SAMPLE_WIDTH'(mid[1]);
            fix.offset_z = SAMPLE_WIDTH'(mid[2]);
            if (item.req_type == REQ_HEAD) begin
                h = cordic_heading(longint'(s[0]) - mid[0], longint'(s[1]) - mid[1]);
                fix.heading = HEADING_W'(h);
                fix.octant = sector_of(h);
                fix.heading_valid = 1'b1;
            end
            owed_fixes.push_back(fix);
        endfunction

        task check_field(string name, longint got, longint want);
            if (got != want) begin
                report($sformatf("%s got %0d want %0d", name, got, want));
            end
        endtask

        task check_fix(t_out got);
            t_out want;
            if (owed_fixes.size() == 0) begin
                report("result transfer with nothing outstanding");
                return;
            end
            want = owed_fixes.pop_front();
            check_field("heading", got.heading, want.heading);
            check_field("octant", got.octant, want.octant);
            check_field("heading_valid", got.heading_valid, want.heading_valid);
            check_field("offset_x", got.offset_x, want.offset_x);
            check_field("offset_y", got.offset_y, want.offset_y);
            check_field("offset_z", got.offset_z, want.offset_z);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    heading_book book = new();
    bit in_quiet;
    bit out_quiet;
    int items_sent;
    int cycle_count;

    compass_heading_with_hard_iron_cal uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) book.check_fix(o_out_data);
            if (i_in_valid && o_in_ready) book.note_sample(i_in_data);
        end
    end

    task automatic send_item(t_in item);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic put(logic [REQ_W-1:0] req, int x, int y, int z);
        t_in item;
        item.req_type = req;
        item.sample_x = SAMPLE_WIDTH'(x);
        item.sample_y = SAMPLE_WIDTH'(y);
        item.sample_z = SAMPLE_WIDTH'(z);
        send_item(item);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 9)) inside
            0: return 32767;
            1: return -32768;
            [2:4]: return int'($urandom_range(0, 400)) - 200;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int near(int c);
        if ($urandom_range(0, 2) == 0) return rand_sample();
        return c + int'($urandom_range(0, 2000)) - 1000;
    endfunction

    // result side: hold ready low at random before each transfer, never while out_quiet is set
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = out_quiet ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        int cx, cy, cz;
        cycle_count = 0;
        items_sent = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero vector and calibration against reset zeros
        put(REQ_HEAD, 0, 0, 0);
        put(REQ_CAL, -32768, 32767, 1);
        put(REQ_HEAD, 32767, -32768, 0);
        put(REQ_UNUSED, 1234, -4321, 77);
        // full-scale extremes
        put(REQ_START, 32767, -32768, -32768);
        put(REQ_CAL, -32768, 32767, 32767);
        put(REQ_HEAD, -32768, 32767, -1);
        put(REQ_HEAD, 32767, -32768, 0);
        // each compass direction
        put(REQ_START, 0, 0, 0);
        put(REQ_HEAD, 0, 100, 0);
        put(REQ_HEAD, 100, 100, 0);
        put(REQ_HEAD, 100, 0, 0);
        put(REQ_HEAD, 100, -100, 0);
        put(REQ_HEAD, 0, -100, 0);
        put(REQ_HEAD, -100, -100, 0);
        put(REQ_HEAD, -100, 0, 0);
        put(REQ_HEAD, -100, 100, 0);
        // odd negative sums truncate toward zero
        put(REQ_START, -3, -5, -7);
        put(REQ_CAL, 0, 0, 0);
        put(REQ_HEAD, -1, -2, 0);
        put(REQ_HEAD, -32768, -32768, -32768);
        put(REQ_UNUSED, -1, -1, -1);
        put(REQ_HEAD, 5, -2, 0);

        while (items_sent < RANDOM_ITEMS) begin
            in_quiet = ($urandom_range(0, 5) == 0);
            out_quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    put(REQ_W'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                        rand_sample());
                end
            end else begin
                cx = rand_sample();
                cy = rand_sample();
                cz = rand_sample();
                put(REQ_START, cx, cy, cz);
                repeat ($urandom_range(0, 8)) put(REQ_CAL, near(cx), near(cy), near(cz));
                repeat ($urandom_range(1, 10)) put(REQ_HEAD, near(cx), near(cy), near(cz));
            end
        end
        i_in_valid <= 1'b0;

        while (book.owed_fixes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (book.mismatches == 0 && book.owed_fixes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### compass_heading_with_hard_iron_cal.f
design/chic_pkg.sv
design/chic_cal.sv
design/chic_cordic.sv
design/compass_heading_with_hard_iron_cal.sv
dv/tb.sv
